/* rtl/rqpa_pkg.sv */
// Shared constants for the ready queue with priority aging.
`default_nettype none
package rqpa_pkg;

	localparam int DEFAULT_QUEUE_DEPTH   = 16;
	localparam int DEFAULT_PRIORITY_BITS = 8;

	localparam int ID_W       = 16;
	localparam int REQ_PRIO_W = 8;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 5;

	typedef logic [MODE_W-1:0]   mode_t;
	typedef logic [STATUS_W-1:0] status_t;

	localparam mode_t MODE_ENQ = 2'd0;
	localparam mode_t MODE_DEQ = 2'd1;
	localparam mode_t MODE_AGE = 2'd2;

	localparam status_t STATUS_OK    = 2'd0;
	localparam status_t STATUS_EMPTY = 2'd1;
	localparam status_t STATUS_FULL  = 2'd2;

endpackage
`default_nettype wire

/* rtl/rqpa_slot_ram.sv */
// Slot storage: one write port, one read port, registered read data.
`default_nettype none
module rqpa_slot_ram
	import rqpa_pkg::*;
#(
	parameter int DEPTH  = DEFAULT_QUEUE_DEPTH,
	parameter int DATA_W = ID_W + DEFAULT_PRIORITY_BITS,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [DATA_W-1:0] wdata,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

/* rtl/ready_queue_priority_aging_core.sv */
// Top level of the bounded ready queue with FIFO or priority insertion and aging.
`default_nettype none
// The queue lives in a circular buffer in one slot RAM (head and tail pointers,
// entry count). A request is taken when start is high and busy is low; every
// request yields exactly one result, shown for a single cycle with done high,
// and the receiver cannot stall it. FIFO enqueue, enqueue into an empty queue,
// any error, age of an empty queue and unused modes give their result in the
// cycle after acceptance and leave busy low. Dequeue reads the head slot and
// passes through S_DEQ. Priority enqueue walks every held entry through the RAM
// read port, rippling entries one slot toward the tail behind the insertion
// point, then writes the tail slot. Aging walks every held entry, decrementing
// nonzero priorities in place. The single RAM read port, one slot per cycle, sets
// the walk length. The user must see that the ordering register is written by
// cfg_we/cfg_data only while the block is idle; the block does not enforce this.
module ready_queue_priority_aging_core
	import rqpa_pkg::*;
#(
	parameter int QUEUE_DEPTH   = DEFAULT_QUEUE_DEPTH,
	parameter int PRIORITY_BITS = DEFAULT_PRIORITY_BITS
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_data,
	// request
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic [MODE_W-1:0]     mode,
	input  wire logic [ID_W-1:0]       entry_id,
	input  wire logic [REQ_PRIO_W-1:0] priority_req,
	// result
	output logic                       done,
	output logic      [ID_W-1:0]       out_id,
	output logic      [REQ_PRIO_W-1:0] out_priority,
	output logic      [STATUS_W-1:0]   status,
	output logic      [COUNT_W-1:0]    count
);

	localparam int IDX_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int P_W    = PRIORITY_BITS;
	localparam int DATA_W = ID_W + P_W;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DEQ  = 2'd1;
	localparam logic [1:0] S_WALK = 2'd2;
	localparam logic [1:0] S_TAIL = 2'd3;

	// control state
	logic [1:0]       state_q;
	logic             ordering_q;
	logic [IDX_W-1:0] head_q;
	logic [IDX_W-1:0] tail_q;
	logic [CNT_W-1:0] occ_q;
	logic [IDX_W-1:0] k_q;       // logical index of slot in rdata during a walk
	logic [IDX_W-1:0] paddr_q;   // physical address of slot in rdata
	logic             is_age_q;  // walk is an aging pass, else an insertion
	logic             inserted_q;
	logic             done_q;

	// payload
	logic [ID_W-1:0]   new_id_q;
	logic [P_W-1:0]    new_pr_q;
	logic [ID_W-1:0]   carry_id_q;
	logic [P_W-1:0]    carry_pr_q;
	logic [ID_W-1:0]   out_id_q;
	logic [P_W-1:0]    out_pr_q;
	logic [STATUS_W-1:0] status_q;

	// RAM port
	logic              we;
	logic [IDX_W-1:0]  waddr;
	logic [DATA_W-1:0] wdata;
	logic [IDX_W-1:0]  raddr;
	logic [DATA_W-1:0] rdata;

	logic [ID_W-1:0]  rd_id;
	logic [P_W-1:0]   rd_pr;
	logic [P_W-1:0]   req_pr;
	logic             full;
	logic             empty;
	logic             last;
	logic [IDX_W-1:0] next_paddr;

	logic [P_W+REQ_PRIO_W-1:0]     req_pr_ext;
	logic [P_W+REQ_PRIO_W-1:0]     out_pr_ext;
	logic [CNT_W+COUNT_W-1:0]      count_ext;

	function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] a);
		if (a == IDX_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end
		return a + IDX_W'(1);
	endfunction

	rqpa_slot_ram #(
		.DEPTH  (QUEUE_DEPTH),
		.DATA_W (DATA_W)
	) u_slot_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_id = rdata[DATA_W-1:P_W];
	assign rd_pr = rdata[P_W-1:0];

	// requested priority keeps its low PRIORITY_BITS bits
	assign req_pr_ext = {{P_W{1'b0}}, priority_req};
	assign req_pr     = req_pr_ext[P_W-1:0];

	assign full       = (occ_q == CNT_W'(QUEUE_DEPTH));
	assign empty      = (occ_q == '0);
	assign last       = ((CNT_W'(k_q) + CNT_W'(1)) == occ_q);
	assign next_paddr = wrap_inc(paddr_q);

	// read address: head when idle, else the slot after the one in hand
	assign raddr = (state_q == S_IDLE) ? head_q : next_paddr;

	// RAM writes
	always_comb begin
		we    = 1'b0;
		waddr = paddr_q;
		wdata = {rd_id, rd_pr};
		unique case (state_q)
			S_IDLE: begin
				// direct tail write for FIFO enqueue or enqueue into an empty queue
				waddr = tail_q;
				wdata = {entry_id, req_pr};
				we    = start && (mode == MODE_ENQ) && !full && (!ordering_q || empty);
			end
			S_WALK: begin
				if (is_age_q) begin
					we    = (rd_pr != '0);
					wdata = {rd_id, rd_pr - P_W'(1)};
				end else if (inserted_q) begin
					we    = 1'b1;
					wdata = {carry_id_q, carry_pr_q};
				end else if (rd_pr > new_pr_q) begin
					we    = 1'b1;
					wdata = {new_id_q, new_pr_q};
				end
			end
			S_TAIL: begin
				we    = 1'b1;
				wdata = inserted_q ? {carry_id_q, carry_pr_q} : {new_id_q, new_pr_q};
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			ordering_q <= 1'b0;
			head_q     <= '0;
			tail_q     <= '0;
			occ_q      <= '0;
			k_q        <= '0;
			paddr_q    <= '0;
			is_age_q   <= 1'b0;
			inserted_q <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cfg_we) begin
				ordering_q <= cfg_data;
			end
			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						k_q        <= '0;
						paddr_q    <= head_q;
						inserted_q <= 1'b0;
						case (mode)
							MODE_ENQ: begin
								if (full) begin
									done_q <= 1'b1;
								end else if (!ordering_q || empty) begin
									tail_q <= wrap_inc(tail_q);
									occ_q  <= occ_q + CNT_W'(1);
									done_q <= 1'b1;
								end else begin
									is_age_q <= 1'b0;
									state_q  <= S_WALK;
								end
							end
							MODE_DEQ: begin
								if (empty) begin
									done_q <= 1'b1;
								end else begin
									state_q <= S_DEQ;
								end
							end
							MODE_AGE: begin
								if (empty) begin
									done_q <= 1'b1;
								end else begin
									is_age_q <= 1'b1;
									state_q  <= S_WALK;
								end
							end
							default: begin
								done_q <= 1'b1;
							end
						endcase
					end
				end
				S_DEQ: begin
					head_q  <= wrap_inc(head_q);
					occ_q   <= occ_q - CNT_W'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				S_WALK: begin
					if (!is_age_q && !inserted_q && (rd_pr > new_pr_q)) begin
						inserted_q <= 1'b1;
					end
					paddr_q <= next_paddr;
					k_q     <= k_q + IDX_W'(1);
					if (last) begin
						if (is_age_q) begin
							done_q  <= 1'b1;
							state_q <= S_IDLE;
						end else begin
							state_q <= S_TAIL;
						end
					end
				end
				S_TAIL: begin
					tail_q  <= wrap_inc(tail_q);
					occ_q   <= occ_q + CNT_W'(1);
					done_q  <= 1'b1;
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// payload: request latch, ripple carry and result fields
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			new_id_q <= entry_id;
			new_pr_q <= req_pr;
			out_id_q <= '0;
			out_pr_q <= '0;
			status_q <= STATUS_OK;
			if (mode == MODE_ENQ && full) begin
				status_q <= STATUS_FULL;
			end else if (mode == MODE_DEQ && empty) begin
				status_q <= STATUS_EMPTY;
			end
		end
		if (state_q == S_DEQ) begin
			out_id_q <= rd_id;
			out_pr_q <= rd_pr;
		end
		// displaced entry moves one slot toward the tail
		if (state_q == S_WALK && (inserted_q || rd_pr > new_pr_q)) begin
			carry_id_q <= rd_id;
			carry_pr_q <= rd_pr;
		end
	end

	assign out_pr_ext = {{REQ_PRIO_W{1'b0}}, out_pr_q};
	assign count_ext  = {{COUNT_W{1'b0}}, occ_q};

	assign busy         = (state_q != S_IDLE);
	assign done         = done_q;
	assign out_id       = out_id_q;
	assign out_priority = out_pr_ext[REQ_PRIO_W-1:0];
	assign status       = status_q;
	assign count        = count_ext[COUNT_W-1:0];

endmodule
`default_nettype wire

/* rtl/rqpa_checker.sv */
// Port-level checks for the ready queue, bound to the top level.
`default_nettype none
module rqpa_checker
	import rqpa_pkg::*;
(
	input wire logic                  clk,
	input wire logic                  arst_n,
	input wire logic                  start,
	input wire logic                  busy,
	input wire logic                  done,
	input wire logic [ID_W-1:0]       out_id,
	input wire logic [REQ_PRIO_W-1:0] out_priority,
	input wire logic [STATUS_W-1:0]   status,
	input wire logic [COUNT_W-1:0]    count
);

	// a result closes its request: never shown while still working
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result strobe while busy");

	// an accepted request either answers next cycle or holds busy
	a_accept_progress: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> (done || busy))
		else $error("accepted request neither answered nor in progress");

	// count only moves together with a result
	a_count_moves: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(count) |-> done)
		else $error("count changed without a result");

	// failed dequeue reports an empty queue
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == STATUS_EMPTY) |-> (count == '0))
		else $error("empty status with nonzero count");

	// errors carry no entry
	a_error_payload: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status != STATUS_OK) |-> (out_id == '0 && out_priority == '0))
		else $error("error result with entry payload");

endmodule

bind ready_queue_priority_aging_core rqpa_checker u_rqpa_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.done         (done),
	.out_id       (out_id),
	.out_priority (out_priority),
	.status       (status),
	.count        (count)
);
`default_nettype wire

/* test/rq_result_monitor.sv */
// Watches the ready queue ports, predicts every result and compares it.
`timescale 1ns / 100ps
module rq_result_monitor
	import rqpa_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic                  cfg_data,
	input  wire logic                  start,
	input  wire logic                  busy,
	input  wire logic [MODE_W-1:0]     mode,
	input  wire logic [ID_W-1:0]       entry_id,
	input  wire logic [REQ_PRIO_W-1:0] priority_req,
	input  wire logic                  done,
	input  wire logic [ID_W-1:0]       out_id,
	input  wire logic [REQ_PRIO_W-1:0] out_priority,
	input  wire logic [STATUS_W-1:0]   status,
	input  wire logic [COUNT_W-1:0]    count,
	output int                         outstanding,
	output int                         mismatches
);

	typedef struct packed {
		logic [ID_W-1:0]       id;
		logic [REQ_PRIO_W-1:0] prio;
		status_t               st;
		logic [COUNT_W-1:0]    cnt;
	} queue_result_t;

	// shadow copy of the queue
	logic [ID_W-1:0]       shadow_id   [DEFAULT_QUEUE_DEPTH];
	logic [REQ_PRIO_W-1:0] shadow_prio [DEFAULT_QUEUE_DEPTH];
	int                    held;
	logic                  prio_order;

	queue_result_t pending_results[$];
	int            fail_tally = 0;

	assign mismatches = fail_tally;

	function automatic queue_result_t predict_queue_op(mode_t m, logic [ID_W-1:0] id,
			logic [REQ_PRIO_W-1:0] p);
		queue_result_t r;
		int            pos;
		r = '0;
		case (m)
			MODE_ENQ: begin
				if (held >= DEFAULT_QUEUE_DEPTH) begin
					r.st = STATUS_FULL;
				end else begin
					pos = held;
					// stable insertion: before the first strictly greater priority
					if (prio_order) begin
						for (int i = 0; i < held; i++)
							if (pos == held && shadow_prio[i] > p)
								pos = i;
					end
					for (int i = held; i > pos; i--) begin
						shadow_id[i]   = shadow_id[i-1];
						shadow_prio[i] = shadow_prio[i-1];
					end
					shadow_id[pos]   = id;
					shadow_prio[pos] = p;
					held++;
				end
			end
			MODE_DEQ: begin
				if (held == 0) begin
					r.st = STATUS_EMPTY;
				end else begin
					r.id   = shadow_id[0];
					r.prio = shadow_prio[0];
					for (int i = 1; i < held; i++) begin
						shadow_id[i-1]   = shadow_id[i];
						shadow_prio[i-1] = shadow_prio[i];
					end
					held--;
				end
			end
			MODE_AGE: begin
				for (int i = 0; i < held; i++)
					if (shadow_prio[i] != '0)
						shadow_prio[i] = shadow_prio[i] - REQ_PRIO_W'(1);
			end
			default: ;
		endcase
		r.cnt = COUNT_W'(held);
		return r;
	endfunction

	task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected 0x%0h, actual 0x%0h", name, exp_v, act_v);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		queue_result_t exp_r;
		if (!arst_n) begin
			held = 0;
			prio_order = 1'b0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (done) begin
				if (pending_results.size() == 0) begin
					$error("result arrived with no request pending");
					fail_tally++;
				end else begin
					exp_r = pending_results.pop_front();
					compare_field("out_id", 32'(exp_r.id), 32'(out_id));
					compare_field("out_priority", 32'(exp_r.prio), 32'(out_priority));
					compare_field("status", 32'(exp_r.st), 32'(status));
					compare_field("count", 32'(exp_r.cnt), 32'(count));
				end
			end
			if (cfg_we)
				prio_order = cfg_data;
			if (start && !busy)
				pending_results.push_back(predict_queue_op(mode, entry_id, priority_req));
			outstanding <= pending_results.size();
		end
	end

endmodule

/* test/testbench.sv */
// Stimulus and verdict for the ready queue core with FIFO/priority insertion and aging.
`timescale 1ns / 100ps
module testbench;
	import rqpa_pkg::*;

	// the spare opcode is a no-op in the block
	localparam mode_t MODE_SPARE = 2'd3;
	localparam int    PHASES     = 5;
	localparam int    PHASE_LEN  = 80;
	localparam int    SEG_LEN    = 40;

	logic                  clk          = 1'b0;
	logic                  arst_n       = 1'b0;
	logic                  cfg_we       = 1'b0;
	logic                  cfg_data     = 1'b0;
	logic                  start        = 1'b0;
	mode_t                 mode         = MODE_ENQ;
	logic [ID_W-1:0]       entry_id     = '0;
	logic [REQ_PRIO_W-1:0] priority_req = '0;

	logic                  busy;
	logic                  done;
	logic [ID_W-1:0]       out_id;
	logic [REQ_PRIO_W-1:0] out_priority;
	logic [STATUS_W-1:0]   status;
	logic [COUNT_W-1:0]    count;

	int outstanding;
	int mismatches;

	always #5 clk = ~clk;

	ready_queue_priority_aging_core dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.entry_id     (entry_id),
		.priority_req (priority_req),
		.done         (done),
		.out_id       (out_id),
		.out_priority (out_priority),
		.status       (status),
		.count        (count)
	);

	rq_result_monitor monitor (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.start        (start),
		.busy         (busy),
		.mode         (mode),
		.entry_id     (entry_id),
		.priority_req (priority_req),
		.done         (done),
		.out_id       (out_id),
		.out_priority (out_priority),
		.status       (status),
		.count        (count),
		.outstanding  (outstanding),
		.mismatches   (mismatches)
	);

	// Present one request and hold it until the block takes it. Called at a
	// rising edge; returns at the edge that accepted the request. start is left
	// high so a back-to-back request needs no extra assignment in this step.
	task automatic send_request(mode_t m, logic [ID_W-1:0] id, logic [REQ_PRIO_W-1:0] p);
		start        <= 1'b1;
		mode         <= m;
		entry_id     <= id;
		priority_req <= p;
		@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	// Sender gap: drop start for a burst of idle cycles.
	task automatic idle_burst(int cycles);
		start <= 1'b0;
		repeat (cycles) @(posedge clk);
	endtask

	// Wait until every predicted result has come back and the block is idle.
	task automatic wait_drained();
		start <= 1'b0;
		@(posedge clk);
		while (outstanding != 0 || busy)
			@(posedge clk);
	endtask

	// The ordering register is only touched while nothing is in flight.
	task automatic write_ordering(logic v);
		wait_drained();
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// One random request. Age and the spare opcode get a small fixed share;
	// the rest splits between enqueue and dequeue by enq_weight so a segment
	// can push the queue toward full or toward empty.
	task automatic random_request(int enq_weight);
		mode_t                 m;
		logic [REQ_PRIO_W-1:0] p;
		int                    r;
		r = $urandom_range(0, 99);
		if (r < 4)
			m = MODE_SPARE;
		else if (r < 14)
			m = MODE_AGE;
		else if ($urandom_range(0, 99) < enq_weight)
			m = MODE_ENQ;
		else
			m = MODE_DEQ;
		// narrow priorities most of the time: lots of ties and aging down to zero
		if ($urandom_range(0, 3) == 0)
			p = REQ_PRIO_W'($urandom_range(0, 255));
		else
			p = REQ_PRIO_W'($urandom_range(0, 7));
		send_request(m, ID_W'($urandom_range(0, 65535)), p);
	endtask

	initial begin
		int n;
		int enq_weight;
		bit gappy;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// --- directed part, FIFO ordering out of reset ---
		// corner cases on an empty queue: dequeue error, aging nothing, spare opcode
		send_request(MODE_DEQ, 16'hFFFF, 8'hFF);
		send_request(MODE_AGE, 16'h0000, 8'h00);
		send_request(MODE_SPARE, 16'hFFFF, 8'hFF);
		// fill to capacity with extreme ids and priorities
		send_request(MODE_ENQ, 16'h0000, 8'h00);
		send_request(MODE_ENQ, 16'hFFFF, 8'hFF);
		send_request(MODE_ENQ, 16'hA5A5, 8'h01);
		for (n = 3; n < DEFAULT_QUEUE_DEPTH; n++)
			send_request(MODE_ENQ, ID_W'(16'h0100 * n + n), REQ_PRIO_W'(n % 3));
		// full queue rejects the enqueue
		send_request(MODE_ENQ, 16'h1234, 8'h10);
		// aging saturates the zero priorities
		send_request(MODE_AGE, 16'h0000, 8'h00);
		send_request(MODE_DEQ, 16'h0000, 8'h00);
		// switch to priority insertion with FIFO-ordered entries still held
		write_ordering(1'b1);
		send_request(MODE_ENQ, 16'h5A5A, 8'h01);
		send_request(MODE_DEQ, 16'h0000, 8'h00);
		send_request(MODE_DEQ, 16'h0000, 8'h00);

		// --- random part: phases alternate the ordering, queue carries over ---
		for (int ph = 0; ph < PHASES; ph++) begin
			write_ordering(ph % 2 == 0 ? 1'b0 : 1'b1);
			for (n = 0; n < PHASE_LEN; n++) begin
				if (n % SEG_LEN == 0) begin
					case ($urandom_range(0, 2))
						0:       enq_weight = 15;
						1:       enq_weight = 50;
						default: enq_weight = 85;
					endcase
					// final phase runs without gaps
					gappy = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
				end
				if (gappy && $urandom_range(0, 3) == 0)
					idle_burst($urandom_range(1, 15));
				random_request(enq_weight);
			end
		end

		// drain, then allow for the longest walk through a full queue
		wait_drained();
		repeat (40) @(posedge clk);
		if (outstanding != 0)
			$error("%0d expected results never arrived", outstanding);
		if (mismatches == 0 && outstanding == 0)
			$display("PASS ready_queue_priority_aging_core");
		else
			$display("FAIL ready_queue_priority_aging_core");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#2_000_000;
		$display("FAIL ready_queue_priority_aging_core");
		$finish;
	end

endmodule
